/* design/clnw_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clnw_pkg: shared types and constants
// Action codes, row base addresses and the handshake structs that pass
// between the sequencer, the decimal converter and the nibble transmitter.
// ----------------------------------------------------------------------------
package clnw_pkg;

  localparam int PAYLOAD_W  = 32;
  localparam int BCD_DIGITS = 10;            // decimal digits of a 32-bit value
  localparam int BCD_W      = 4 * BCD_DIGITS;
  localparam int CNT_W      = $clog2(PAYLOAD_W + 1);
  localparam int IDX_W      = $clog2(BCD_DIGITS);

  typedef enum logic [1:0] {
    ACT_CMD    = 2'd0,
    ACT_DATA   = 2'd1,
    ACT_CURSOR = 2'd2,
    ACT_NUMBER = 2'd3
  } action_t;

  localparam logic       RS_CMD     = 1'b0;
  localparam logic       RS_DATA    = 1'b1;
  localparam logic [7:0] CURSOR_CMD = 8'h80;
  localparam logic [7:0] ASCII_ZERO = 8'h30;

  localparam logic [7:0] ROW_BASE [4] = '{8'h80, 8'hC0, 8'h94, 8'hD4};

  typedef struct packed {
    logic       valid;
    logic       rs;
    logic [7:0] data;
    logic       last;
  } byte_req_t;

  typedef struct packed {
    logic start;
    logic shift;
  } conv_ctrl_t;

  typedef struct packed {
    logic       done;
    logic [3:0] digit;
  } conv_stat_t;

endpackage

/* design/clnw_in_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clnw_in_if: request channel
// One beat carries an action code with its payload and cursor position.
// ----------------------------------------------------------------------------
interface clnw_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  action;
  logic [31:0] payload;
  logic [7:0]  row;
  logic [7:0]  col;

  modport source (output valid, action, payload, row, col, input ready);
  modport sink   (input valid, action, payload, row, col, output ready);
endinterface

/* design/clnw_out_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clnw_out_if: strobe channel
// One beat is one enable strobe on the 4-bit LCD bus.
// ----------------------------------------------------------------------------
interface clnw_out_if;
  logic       valid;
  logic       ready;
  logic       reg_select;
  logic [3:0] bus_nibble;
  logic       last;

  modport source (output valid, reg_select, bus_nibble, last, input ready);
  modport sink   (input valid, reg_select, bus_nibble, last, output ready);
endinterface

/* design/char_lcd_nibble_writer_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// char_lcd_nibble_writer_top: 4-bit character LCD writer
// Timing: a byte or cursor action is registered as the pending byte, and the
//   transmitter registers that byte before it offers the first strobe; a
//   number is converted bit-serially before its digits are walked.
// Throughput: one strobe per cycle at best, while out_ch.ready holds; each
//   byte goes out as two strobes, and a new request beat is taken only
//   once the sequencer is back in idle.
// Reset: synchronous, active high; returns to idle with no strobe pending.
// ----------------------------------------------------------------------------
module char_lcd_nibble_writer_top
  import clnw_pkg::*;
#(
  parameter int NUM_ROWS   = 4,
  parameter int NUM_COLS   = 16,
  parameter int MAX_DIGITS = 10
) (
  input  logic       clk,
  input  logic       rst,
  clnw_in_if.sink    in_ch,
  clnw_out_if.source out_ch
);

  // Only the lowest DIGIT_CAP digits of a number go out.
  localparam int CAP_A     = (MAX_DIGITS < NUM_COLS) ? MAX_DIGITS : NUM_COLS;
  localparam int DIGIT_CAP = (CAP_A < 16) ? CAP_A : 16;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,  // waiting for a request beat
    S_BYTE = 4'b0010,  // offering the pending byte to the transmitter
    S_CONV = 4'b0100,  // waiting for the decimal conversion
    S_SCAN = 4'b1000   // walking the digits, most significant first
  } state_t;

  state_t state, state_next;

  // Pending byte for command, data and cursor transfers.
  logic       pend_rs,   pend_rs_next;
  logic [7:0] pend_byte, pend_byte_next;
  logic       pend_last, pend_last_next;
  logic       pend_conv, pend_conv_next;   // a number follows the cursor byte

  // Digit walk: index of the digit under the converter's top slot, and
  // whether a nonzero digit has been seen (ends leading-zero suppression).
  logic [IDX_W-1:0] idx,  idx_next;
  logic             seen, seen_next;

  logic       in_fire;
  logic       cur_ok;
  logic [7:0] cur_byte;
  logic       emit;

  byte_req_t  req;
  logic       req_ready;
  conv_ctrl_t conv_ctrl;
  conv_stat_t conv_stat;

  assign in_ch.ready = (state == S_IDLE);
  assign in_fire     = in_ch.valid && in_ch.ready;

  // NUM_ROWS must not exceed 4 (the block does not enforce it); then this also keeps the row base index in range.
  assign cur_ok   = (in_ch.row < 8'(NUM_ROWS)) && (in_ch.col < 8'(NUM_COLS));
  assign cur_byte = CURSOR_CMD | (ROW_BASE[in_ch.row[1:0]] + in_ch.col);

  // A digit goes out once it is inside the cap and not a leading zero;
  // the units digit always goes out, so zero prints as a single '0'.
  assign emit = ({1'b0, idx} < (IDX_W + 1)'(DIGIT_CAP)) &&
                (seen || (conv_stat.digit != 4'h0) || (idx == '0));

  always_comb begin
    state_next     = state;
    pend_rs_next   = pend_rs;
    pend_byte_next = pend_byte;
    pend_last_next = pend_last;
    pend_conv_next = pend_conv;
    idx_next       = idx;
    seen_next      = seen;
    conv_ctrl      = '0;
    req            = '0;

    case (state)
      S_IDLE: begin
        if (in_fire) begin
          idx_next       = IDX_W'(BCD_DIGITS - 1);
          seen_next      = 1'b0;
          pend_conv_next = 1'b0;
          pend_last_next = 1'b1;
          case (action_t'(in_ch.action))
            ACT_CMD, ACT_DATA: begin
              pend_rs_next   = (action_t'(in_ch.action) == ACT_DATA) ? RS_DATA : RS_CMD;
              pend_byte_next = in_ch.payload[7:0];
              state_next     = S_BYTE;
            end
            ACT_CURSOR: begin
              pend_rs_next   = RS_CMD;
              pend_byte_next = cur_byte;
              if (cur_ok) begin
                state_next = S_BYTE;
              end
            end
            ACT_NUMBER: begin
              conv_ctrl.start = 1'b1;
              pend_rs_next    = RS_CMD;
              pend_byte_next  = cur_byte;
              pend_last_next  = 1'b0;
              pend_conv_next  = 1'b1;
              // Digits are written even when the cursor command is dropped.
              state_next      = cur_ok ? S_BYTE : S_CONV;
            end
            default: begin
              state_next = S_IDLE;
            end
          endcase
        end
      end

      S_BYTE: begin
        req.valid = 1'b1;
        req.rs    = pend_rs;
        req.data  = pend_byte;
        req.last  = pend_last;
        if (req_ready) begin
          state_next = pend_conv ? S_CONV : S_IDLE;
        end
      end

      S_CONV: begin
        if (conv_stat.done) begin
          state_next = S_SCAN;
        end
      end

      S_SCAN: begin
        req.valid = emit;
        req.rs    = RS_DATA;
        req.data  = ASCII_ZERO | {4'h0, conv_stat.digit};
        req.last  = (idx == '0);
        if (!emit || req_ready) begin
          conv_ctrl.shift = 1'b1;
          seen_next       = seen || (conv_stat.digit != 4'h0);
          if (idx == '0) begin
            state_next = S_IDLE;
          end else begin
            idx_next = idx - 1'b1;
          end
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    pend_rs   <= pend_rs_next;
    pend_byte <= pend_byte_next;
    pend_last <= pend_last_next;
    pend_conv <= pend_conv_next;
    idx       <= idx_next;
    seen      <= seen_next;
  end

  clnw_bin2bcd u_bin2bcd (
    .clk   (clk),
    .rst   (rst),
    .ctrl  (conv_ctrl),
    .value (in_ch.payload),
    .stat  (conv_stat)
  );

  clnw_nib_tx u_nib_tx (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .req_ready (req_ready),
    .out_ch    (out_ch)
  );

endmodule

/* design/clnw_bin2bcd.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clnw_bin2bcd: serial binary to BCD converter
// Shift-and-add-3, one payload bit per cycle; digits then leave top first.
// ----------------------------------------------------------------------------
module clnw_bin2bcd
  import clnw_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  conv_ctrl_t           ctrl,
  input  logic [PAYLOAD_W-1:0] value,
  output conv_stat_t           stat
);

  logic [PAYLOAD_W-1:0] bin;
  logic [BCD_W-1:0]     bcd;
  logic [BCD_W-1:0]     bcd_adj;
  logic [CNT_W-1:0]     cnt;

  always_comb begin
    for (int k = 0; k < BCD_DIGITS; k++) begin
      bcd_adj[4*k +: 4] = (bcd[4*k +: 4] >= 4'd5) ? bcd[4*k +: 4] + 4'd3 : bcd[4*k +: 4];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (ctrl.start) begin
      cnt <= CNT_W'(PAYLOAD_W);
    end else if (cnt != '0) begin
      cnt <= cnt - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.start) begin
      bin <= value;
      bcd <= '0;
    end else if (cnt != '0) begin
      {bcd, bin} <= {bcd_adj[BCD_W-2:0], bin, 1'b0};
    end else if (ctrl.shift) begin
      bcd <= {bcd[BCD_W-5:0], 4'h0};
    end
  end

  assign stat.done  = (cnt == '0);
  assign stat.digit = bcd[BCD_W-1 -: 4];

endmodule

/* design/clnw_nib_tx.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clnw_nib_tx: byte to nibble transmitter
// Holds one byte and sends it as high nibble then low nibble, one beat each.
// ----------------------------------------------------------------------------
module clnw_nib_tx
  import clnw_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  byte_req_t  req,
  output logic       req_ready,
  clnw_out_if.source out_ch
);

  logic       busy;
  logic       hi;
  logic       rs;
  logic       last;
  logic [7:0] data;

  logic out_fire;

  assign out_fire  = out_ch.valid && out_ch.ready;
  assign req_ready = !busy || (!hi && out_ch.ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      hi   <= 1'b0;
    end else if (req.valid && req_ready) begin
      busy <= 1'b1;
      hi   <= 1'b1;
    end else if (out_fire) begin
      if (hi) begin
        hi <= 1'b0;
      end else begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.valid && req_ready) begin
      rs   <= req.rs;
      data <= req.data;
      last <= req.last;
    end
  end

  assign out_ch.valid      = busy;
  assign out_ch.reg_select = rs;
  assign out_ch.bus_nibble = hi ? data[7:4] : data[3:0];
  assign out_ch.last       = last && !hi;

endmodule
